@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define DQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define DQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

@@ rtl/dq_pkg.sv @@
// shared constants and types for the double-ended queue
`timescale 1ns / 1ps
package dq_pkg;

	localparam int DATA_W      = 32;
	localparam int DEPTH_DEF   = 16;

	// mode codes
	localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [2:0] MODE_POP_BACK   = 3'd3;
	localparam logic [2:0] MODE_LIST       = 3'd4;

	// status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

	// operation broadcast to every cell in a cycle
	typedef struct packed {
		logic shift_back;   // push front: everything moves one cell back
		logic shift_fwd;    // pop front: everything moves one cell forward
		logic push_back;    // first free cell loads the pushed value
		logic pop_back;     // tail cell drops its element
		logic tag_load;     // mark the tail element before a listing
		logic rotate;       // listing: head goes to tail, rest moves forward
	} cell_cmd_t;

endpackage

@@ rtl/dq_cell.sv @@
// one storage cell of the deque chain
`timescale 1ns / 1ps
module dq_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dq_pkg::cell_cmd_t              cmd,
	input  logic [dq_pkg::DATA_W-1:0]      push_data,
	input  logic [dq_pkg::DATA_W-1:0]      prev_data,
	input  logic                           prev_valid,
	input  logic [dq_pkg::DATA_W-1:0]      next_data,
	input  logic                           next_valid,
	input  logic                           next_tag,
	input  logic [dq_pkg::DATA_W-1:0]      head_data,
	input  logic                           head_tag,
	output logic [dq_pkg::DATA_W-1:0]      data,
	output logic                           valid,
	output logic                           tag,
	output logic                           is_tail
);

	logic [dq_pkg::DATA_W-1:0] data_q;
	logic                      valid_q;
	logic                      tag_q;
	logic                      is_slot;

	// tail holds the back element, slot is the first free cell
	assign is_tail = valid_q & ~next_valid;
	assign is_slot = ~valid_q & prev_valid;

	// occupancy flag and listing tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tag_q   <= 1'b0;
		end else begin
			if (cmd.shift_back) begin
				valid_q <= prev_valid;
			end else if (cmd.shift_fwd) begin
				valid_q <= next_valid;
			end else if (cmd.push_back && is_slot) begin
				valid_q <= 1'b1;
			end else if (cmd.pop_back && is_tail) begin
				valid_q <= 1'b0;
			end
			if (cmd.tag_load) begin
				tag_q <= is_tail;
			end else if (cmd.rotate) begin
				tag_q <= is_tail ? head_tag : next_tag;
			end
		end
	end

	// element payload
	always_ff @(posedge clk) begin
		if (cmd.shift_back) begin
			data_q <= prev_data;
		end else if (cmd.shift_fwd) begin
			data_q <= next_data;
		end else if (cmd.push_back && is_slot) begin
			data_q <= push_data;
		end else if (cmd.rotate) begin
			data_q <= is_tail ? head_data : next_data;
		end
	end

	assign data  = data_q;
	assign valid = valid_q;
	assign tag   = tag_q;

endmodule

@@ rtl/double_ended_queue_core.sv @@
// top level: deque built from a chain of cells plus the command sequencer
//
// The front element always sits in the first cell and the elements fill the
// chain without gaps, so every push and pop either shifts the chain by one
// cell or acts on its tail cell alone: a command is accepted whenever busy is
// low, and its single result shows on the result ports, with strobe high, in
// the cycle after acceptance. A listing of n stored elements rotates the chain
// once per cycle: busy stays high while it rotates, and the n results come out
// one per cycle, each in the cycle after the rotation that reads it. The
// first rotation runs once state_q has moved to S_LIST on acceptance. The
// last result, with last high, shows in the cycle in which busy falls. The next
// command is taken at the end of that cycle at the earliest. Listing an empty
// queue gives one underflow result and no busy time. Results are never held
// back; the receiver must take each one in the cycle it is shown. Modes 5 to
// 7 are accepted and give no result.
`timescale 1ns / 1ps
module double_ended_queue_core #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [2:0]                        mode,
	input  logic signed [dq_pkg::DATA_W-1:0]  value,
	output logic                              strobe,
	output logic signed [dq_pkg::DATA_W-1:0]  value_out,
	output logic [1:0]                        status,
	output logic                              last
);

	localparam int W = dq_pkg::DATA_W;

	typedef enum logic {
		S_IDLE,
		S_LIST
	} state_t;

	state_t             state_q;
	logic               strobe_q;
	logic [W-1:0]       value_q;
	logic [1:0]         status_q;
	logic               last_q;

	dq_pkg::cell_cmd_t  cmd;
	logic               accept;
	logic               empty;
	logic               full;
	logic [W-1:0]       cell_data  [DEPTH];
	logic [DEPTH-1:0]   cell_valid;
	logic [DEPTH-1:0]   cell_tag;
	logic [DEPTH-1:0]   cell_tail;
	logic [W-1:0]       tail_data;

	assign accept = start & (state_q == S_IDLE);
	assign empty  = ~cell_valid[0];
	assign full   = cell_valid[DEPTH-1];

	// chain of cells, front at index 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [W-1:0] prev_d;
		logic         prev_v;
		logic [W-1:0] next_d;
		logic         next_v;
		logic         next_t;

		if (i == 0) begin : g_first
			assign prev_d = value;
			assign prev_v = 1'b1;
		end else begin : g_mid
			assign prev_d = cell_data[i-1];
			assign prev_v = cell_valid[i-1];
		end

		if (i == DEPTH-1) begin : g_end
			assign next_d = '0;
			assign next_v = 1'b0;
			assign next_t = 1'b0;
		end else begin : g_inner
			assign next_d = cell_data[i+1];
			assign next_v = cell_valid[i+1];
			assign next_t = cell_tag[i+1];
		end

		dq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.push_data  (value),
			.prev_data  (prev_d),
			.prev_valid (prev_v),
			.next_data  (next_d),
			.next_valid (next_v),
			.next_tag   (next_t),
			.head_data  (cell_data[0]),
			.head_tag   (cell_tag[0]),
			.data       (cell_data[i]),
			.valid      (cell_valid[i]),
			.tag        (cell_tag[i]),
			.is_tail    (cell_tail[i])
		);
	end

	// back element, picked by the one-hot tail flags
	always_comb begin
		tail_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_data = tail_data | (cell_data[i] & {W{cell_tail[i]}});
		end
	end

	// chain operation for this cycle
	always_comb begin
		cmd        = '0;
		cmd.rotate = (state_q == S_LIST);
		if (accept) begin
			unique case (mode)
				dq_pkg::MODE_PUSH_FRONT: cmd.shift_back = ~full;
				dq_pkg::MODE_PUSH_BACK:  cmd.push_back  = ~full;
				dq_pkg::MODE_POP_FRONT:  cmd.shift_fwd  = ~empty;
				dq_pkg::MODE_POP_BACK:   cmd.pop_back   = ~empty;
				dq_pkg::MODE_LIST:       cmd.tag_load   = ~empty;
				default: ;
			endcase
		end
	end

	// sequencer state and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
			value_q  <= '0;
			status_q <= dq_pkg::STATUS_OK;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_LIST: begin
					strobe_q <= 1'b1;
					value_q  <= cell_data[0];
					status_q <= dq_pkg::STATUS_OK;
					last_q   <= cell_tag[0];
					if (cell_tag[0]) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (mode)
							dq_pkg::MODE_PUSH_FRONT, dq_pkg::MODE_PUSH_BACK: begin
								strobe_q <= 1'b1;
								value_q  <= '0;
								status_q <= full ? dq_pkg::STATUS_OVERFLOW
								                 : dq_pkg::STATUS_OK;
								last_q   <= 1'b1;
							end
							dq_pkg::MODE_POP_FRONT, dq_pkg::MODE_POP_BACK: begin
								strobe_q <= 1'b1;
								last_q   <= 1'b1;
								if (empty) begin
									value_q  <= '0;
									status_q <= dq_pkg::STATUS_UNDERFLOW;
								end else begin
									value_q  <= (mode == dq_pkg::MODE_POP_FRONT)
									            ? cell_data[0] : tail_data;
									status_q <= dq_pkg::STATUS_OK;
								end
							end
							dq_pkg::MODE_LIST: begin
								if (empty) begin
									strobe_q <= 1'b1;
									value_q  <= '0;
									status_q <= dq_pkg::STATUS_UNDERFLOW;
									last_q   <= 1'b1;
								end else begin
									state_q <= S_LIST;
								end
							end
							default: ;
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy      = (state_q == S_LIST);
	assign strobe    = strobe_q;
	assign value_out = value_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

@@ rtl/dq_checker.sv @@
// port-level checks for the deque core, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic [2:0]                        mode,
	input logic signed [dq_pkg::DATA_W-1:0]  value_out,
	input logic                              strobe,
	input logic [1:0]                        status,
	input logic                              last
);

	logic take;
	logic single_mode;
	logic known_mode;

	// transaction taken this cycle, and what kind of mode it carries
	assign take        = start && !busy;
	assign single_mode = (mode == dq_pkg::MODE_PUSH_FRONT) || (mode == dq_pkg::MODE_PUSH_BACK)
	                  || (mode == dq_pkg::MODE_POP_FRONT) || (mode == dq_pkg::MODE_POP_BACK);
	assign known_mode  = single_mode || (mode == dq_pkg::MODE_LIST);

	// error results are single and carry no element
	`DQ_ASSERT_NOW(a_err_last, strobe && (status != dq_pkg::STATUS_OK), last)
	`DQ_ASSERT_NOW(a_err_zero, strobe && (status != dq_pkg::STATUS_OK), value_out == '0)

	// every push or pop transaction answers in the next cycle
	`DQ_ASSERT_NEXT(a_single, take && single_mode, strobe && last)

	// unused modes give no result
	`DQ_ASSERT_NEXT(a_unused, take && !known_mode, !strobe)

	// a listing ends together with its final result
	`DQ_ASSERT_NOW(a_list_end, $fell(busy), strobe && last)

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.mode      (mode),
	.value_out (value_out),
	.strobe    (strobe),
	.status    (status),
	.last      (last)
);

@@ test/testbench.sv @@
// self-checking testbench for the double-ended queue core
`timescale 1ns / 1ps
module testbench;

	localparam int QUEUE_DEPTH = dq_pkg::DEPTH_DEF;
	localparam int CLK_PERIOD = 12;
	localparam logic [2:0] MODE_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] MODE_MID_UNUSED = 3'd6;
	localparam logic [2:0] MODE_LAST_UNUSED = 3'd7;

	// one result transaction as it shows on the result ports
	typedef struct packed {
		logic signed [dq_pkg::DATA_W-1:0] value_out;
		logic [1:0]                       status;
		logic                             last;
	} dq_reply_t;

	logic                             clk;
	logic                             arst_n;
	logic                             start;
	logic                             busy;
	logic [2:0]                       mode;
	logic signed [dq_pkg::DATA_W-1:0] value;
	logic                             strobe;
	logic signed [dq_pkg::DATA_W-1:0] value_out;
	logic [1:0]                       status;
	logic                             last;

	// shadow copy of the queue contents, front first
	logic signed [dq_pkg::DATA_W-1:0] deque_shadow[$];
	// replies still owed by the block, oldest first
	dq_reply_t                        due_replies[$];
	int unsigned                      mismatches;
	int unsigned                      idle_pct;

	double_ended_queue_core #(
		.DEPTH(QUEUE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.value(value),
		.strobe(strobe),
		.value_out(value_out),
		.status(status),
		.last(last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// apply one accepted command to the shadow queue and queue up its replies
	function automatic void apply_command(input logic [2:0] m,
		input logic signed [dq_pkg::DATA_W-1:0] v);
		dq_reply_t r;
		r.value_out = '0;
		r.status = dq_pkg::STATUS_OK;
		r.last = 1'b1;
		case (m)
			dq_pkg::MODE_PUSH_FRONT, dq_pkg::MODE_PUSH_BACK: begin
				if (deque_shadow.size() >= QUEUE_DEPTH)
					r.status = dq_pkg::STATUS_OVERFLOW;
				else if (m == dq_pkg::MODE_PUSH_FRONT)
					deque_shadow.push_front(v);
				else
					deque_shadow.push_back(v);
				due_replies.push_back(r);
			end
			dq_pkg::MODE_POP_FRONT, dq_pkg::MODE_POP_BACK: begin
				if (deque_shadow.size() == 0)
					r.status = dq_pkg::STATUS_UNDERFLOW;
				else if (m == dq_pkg::MODE_POP_FRONT)
					r.value_out = deque_shadow.pop_front();
				else
					r.value_out = deque_shadow.pop_back();
				due_replies.push_back(r);
			end
			dq_pkg::MODE_LIST: begin
				if (deque_shadow.size() == 0) begin
					r.status = dq_pkg::STATUS_UNDERFLOW;
					due_replies.push_back(r);
				end else begin
					foreach (deque_shadow[k]) begin
						r.value_out = deque_shadow[k];
						r.last = (k == deque_shadow.size() - 1);
						due_replies.push_back(r);
					end
				end
			end
			default: ;
		endcase
	endfunction

	// element value, now and then one of the extremes
	function automatic logic signed [dq_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(15))
			0: pick_value = 32'sh7fffffff;
			1: pick_value = 32'sh80000000;
			2: pick_value = '0;
			3: pick_value = -1;
			default: pick_value = $urandom;
		endcase
	endfunction

	// send one command transaction; entered and left just after a falling edge
	task automatic send_command(input logic [2:0] m,
		input logic signed [dq_pkg::DATA_W-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		mode = m;
		value = v;
		do
			@(posedge clk);
		while (busy);
		apply_command(m, v);
		@(negedge clk);
	endtask

	// hold off until every owed reply has come
	task automatic wait_idle();
		start = 1'b0;
		while (due_replies.size() != 0)
			@(negedge clk);
	endtask

	// pops and listing on an empty queue
	task automatic test_empty_queue();
		send_command(dq_pkg::MODE_POP_FRONT, pick_value());
		send_command(dq_pkg::MODE_POP_BACK, pick_value());
		send_command(dq_pkg::MODE_LIST, pick_value());
		wait_idle();
	endtask

	// unused modes leave no trace
	task automatic test_unused_modes();
		send_command(MODE_FIRST_UNUSED, 32'sh7fffffff);
		send_command(MODE_LAST_UNUSED, 32'sh80000000);
		send_command(dq_pkg::MODE_POP_FRONT, '0);
		wait_idle();
	endtask

	// value extremes at both ends, then removal of the last element
	task automatic test_value_extremes();
		send_command(dq_pkg::MODE_PUSH_BACK, 32'sh7fffffff);
		send_command(dq_pkg::MODE_PUSH_FRONT, 32'sh80000000);
		send_command(dq_pkg::MODE_PUSH_BACK, -1);
		send_command(dq_pkg::MODE_LIST, '0);
		send_command(dq_pkg::MODE_POP_BACK, '0);
		send_command(dq_pkg::MODE_POP_FRONT, '0);
		send_command(dq_pkg::MODE_POP_FRONT, '0);
		send_command(dq_pkg::MODE_LIST, '0);
		wait_idle();
	endtask

	// fill to the brim, overflow at both ends, full listing, then drain
	task automatic test_full_queue();
		while (deque_shadow.size() < QUEUE_DEPTH)
			send_command($urandom_range(1) ? dq_pkg::MODE_PUSH_BACK : dq_pkg::MODE_PUSH_FRONT,
				pick_value());
		send_command(dq_pkg::MODE_PUSH_FRONT, pick_value());
		send_command(dq_pkg::MODE_PUSH_BACK, pick_value());
		send_command(dq_pkg::MODE_LIST, pick_value());
		wait_idle();
		while (deque_shadow.size() != 0)
			send_command($urandom_range(1) ? dq_pkg::MODE_POP_BACK : dq_pkg::MODE_POP_FRONT,
				pick_value());
		send_command(dq_pkg::MODE_POP_BACK, pick_value());
		wait_idle();
	endtask

	// random traffic in bursts that lean toward filling or draining
	task automatic test_random_traffic(input int unsigned count, input int unsigned gap);
		int unsigned sent;
		int unsigned push_bias;
		int unsigned pick;
		logic [2:0]  op;
		idle_pct = gap;
		sent = 0;
		push_bias = 50;
		while (sent < count) begin
			if ($urandom_range(19) == 0) begin
				case ($urandom_range(2))
					0: push_bias = 85;
					1: push_bias = 50;
					default: push_bias = 15;
				endcase
			end
			pick = $urandom_range(99);
			if (pick < 3) begin
				case ($urandom_range(2))
					0: op = MODE_FIRST_UNUSED;
					1: op = MODE_MID_UNUSED;
					default: op = MODE_LAST_UNUSED;
				endcase
			end else if (pick < 13) begin
				op = dq_pkg::MODE_LIST;
			end else if ($urandom_range(99) < push_bias) begin
				op = $urandom_range(1) ? dq_pkg::MODE_PUSH_BACK : dq_pkg::MODE_PUSH_FRONT;
			end else begin
				op = $urandom_range(1) ? dq_pkg::MODE_POP_BACK : dq_pkg::MODE_POP_FRONT;
			end
			send_command(op, pick_value());
			if (op <= dq_pkg::MODE_LIST)
				sent++;
		end
		wait_idle();
	endtask

	// compare each result transaction with the oldest owed reply
	always @(posedge clk) begin : check_replies
		dq_reply_t want;
		if (arst_n && strobe) begin
			if (due_replies.size() == 0) begin
				$error("unexpected result: value_out %0d status %0d last %0d",
					value_out, status, last);
				mismatches++;
			end else begin
				want = due_replies.pop_front();
				if (value_out !== want.value_out) begin
					$error("value_out: expected %0d, got %0d", want.value_out, value_out);
					mismatches++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					mismatches++;
				end
			end
		end
	end

	// reset, directed tests, random phases, verdict
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = dq_pkg::MODE_PUSH_FRONT;
		value = '0;
		mismatches = 0;
		idle_pct = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_queue();
		test_unused_modes();
		test_value_extremes();
		test_full_queue();
		test_random_traffic(103, 21);
		test_random_traffic(103, 61);
		test_random_traffic(104, 0);

		wait_idle();
		repeat (QUEUE_DEPTH + 4) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ double_ended_queue_core.f @@
+incdir+rtl
rtl/dq_pkg.sv
rtl/dq_cell.sv
rtl/double_ended_queue_core.sv
rtl/dq_checker.sv
test/testbench.sv
